// File: hw/rtl/lce_pkg.sv
// lce_pkg: shared types and constants for the lru cache with expiry
// used by lce_cell, lru_cache_with_expiry and lce_checker; depends on nothing
`default_nettype none

package lce_pkg;

    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;
    localparam int TIME_W     = 32;
    localparam int CAP_W      = 5;
    localparam int OCC_OUT_W  = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        CMD_GET  = 2'd0,
        CMD_PUT  = 2'd1,
        CMD_TICK = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        STS_HIT      = 3'd0,
        STS_MISS     = 3'd1,
        STS_EXPIRED  = 3'd2,
        STS_INSERTED = 3'd3,
        STS_UPDATED  = 3'd4,
        STS_EVICTED  = 3'd5,
        STS_TICK     = 3'd6
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY = 1'd0,
        CFG_TTL      = 1'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_INSERT
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_MATCH,
        CELL_PUSH,
        CELL_PULL
    } t_cell_op;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [TIME_W-1:0] expiry;
    } t_entry;

    typedef struct packed {
        t_cell_op         op;
        logic [KEY_W-1:0] key;
    } t_cell_ctl;

    typedef struct packed {
        logic [1:0]       command;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_cmd_in;

    typedef struct packed {
        logic [2:0]           status;
        logic [VAL_W-1:0]     read_value;
        logic [KEY_W-1:0]     evicted_key;
        logic [OCC_OUT_W-1:0] occupancy;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/lce_cell.sv
// lce_cell: one slot of the recency chain, holding one entry and its key match
// depends on lce_pkg; position in the chain is the recency rank (0 = most recent)
`default_nettype none

module lce_cell #(
    parameter int PW       = 4,
    parameter int CELL_IDX = 0
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lce_pkg::t_cell_ctl i_ctl,
    input  wire logic [PW-1:0]      i_pos,
    input  wire lce_pkg::t_entry    i_left,
    input  wire lce_pkg::t_entry    i_right,
    output lce_pkg::t_entry         o_entry,
    output logic                    o_match
);

    localparam logic [PW-1:0] IDX = PW'(CELL_IDX);

    logic                           r_valid;
    logic                           r_match;
    logic [lce_pkg::KEY_W-1:0]      r_key;
    logic [lce_pkg::VAL_W-1:0]      r_value;
    logic [lce_pkg::TIME_W-1:0]     r_expiry;
    logic                           take_left;
    logic                           take_right;

    // push shifts the front part of the chain down, pull closes a gap
    assign take_left  = (i_ctl.op == lce_pkg::CELL_PUSH) && (IDX <= i_pos);
    assign take_right = (i_ctl.op == lce_pkg::CELL_PULL) && (IDX >= i_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.op == lce_pkg::CELL_MATCH) begin
                r_match <= r_valid && (r_key == i_ctl.key);
            end
            if (take_left) begin
                r_valid <= i_left.valid;
            end else if (take_right) begin
                r_valid <= i_right.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_left) begin
            r_key    <= i_left.key;
            r_value  <= i_left.value;
            r_expiry <= i_left.expiry;
        end else if (take_right) begin
            r_key    <= i_right.key;
            r_value  <= i_right.value;
            r_expiry <= i_right.expiry;
        end
    end

    assign o_entry.valid  = r_valid;
    assign o_entry.key    = r_key;
    assign o_entry.value  = r_value;
    assign o_entry.expiry = r_expiry;
    assign o_match        = r_match;

endmodule

`default_nettype wire

// File: hw/rtl/lru_cache_with_expiry.sv
// lru_cache_with_expiry: a beat is accepted in idle and resolved in the exec state (a put whose key
// has expired also visits the insert state: remove pass, then insert pass); new beats are taken only in idle.
// accept registers the key match in every cell, the exec state decides and shifts the chain.
// o_done pulses one cycle; busy is low in that cycle so the next start is taken there.
// synchronous active-low reset empties the chain, clears time, ttl 0, capacity 16.
// depends on lce_pkg and lce_cell
`default_nettype none

module lru_cache_with_expiry #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire lce_pkg::t_cmd_in                   i_in,
    output logic                                    o_done,
    output lce_pkg::t_result                        o_out,
    input  wire logic                               i_cfg_we,
    input  wire logic [lce_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [lce_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int PW    = $clog2(MAX_ENTRIES);
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int CW    = (OCC_W > lce_pkg::CAP_W) ? OCC_W : lce_pkg::CAP_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

    lce_pkg::t_state                r_state, n_state;
    logic [lce_pkg::CAP_W-1:0]      r_cap;
    logic [lce_pkg::TIME_W-1:0]     r_ttl;
    logic [lce_pkg::TIME_W-1:0]     r_time, n_time;
    logic [OCC_W-1:0]               r_occ, n_occ;
    lce_pkg::t_cmd                  r_cmd;
    logic [lce_pkg::KEY_W-1:0]      r_key;
    logic [lce_pkg::VAL_W-1:0]      r_value;
    logic [lce_pkg::TIME_W-1:0]     r_new_exp;
    logic                           r_done, n_done;
    lce_pkg::t_result               r_result, n_result;

    lce_pkg::t_entry                cell_q     [MAX_ENTRIES];
    lce_pkg::t_entry                left_in    [MAX_ENTRIES];
    lce_pkg::t_entry                right_in   [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]         match;
    lce_pkg::t_cell_ctl             cell_ctl;
    logic [PW-1:0]                  cell_pos;
    lce_pkg::t_entry                new_entry;

    logic                           accept;
    logic                           any_match;
    logic [PW-1:0]                  pos_m;
    lce_pkg::t_entry                hit_entry;
    logic                           expired;
    logic                           ttl_on;
    logic [lce_pkg::TIME_W:0]       exp_sum;
    logic [CW-1:0]                  cap_ext, cap_eff;
    logic                           evict;
    logic [PW-1:0]                  lru_idx;
    logic [PW-1:0]                  ins_pos;
    lce_pkg::t_entry                ins_entry;

    assign accept = start && !busy;
    assign busy   = (r_state != lce_pkg::ST_IDLE);
    assign ttl_on = (r_ttl != '0);

    // ---------------- cell chain ----------------
    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign left_in[g] = new_entry;
            end else begin : g_body
                assign left_in[g] = cell_q[g-1];
            end
            if (g == MAX_ENTRIES - 1) begin : g_tail
                assign right_in[g] = '0;
            end else begin : g_mid
                assign right_in[g] = cell_q[g+1];
            end
            lce_cell #(
                .PW       (PW),
                .CELL_IDX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (cell_ctl),
                .i_pos   (cell_pos),
                .i_left  (left_in[g]),
                .i_right (right_in[g]),
                .o_entry (cell_q[g]),
                .o_match (match[g])
            );
        end
    endgenerate

    // keys are unique among valid cells, so at most one match bit is set
    always_comb begin
        pos_m     = '0;
        hit_entry = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (match[i]) begin
                pos_m     = pos_m | PW'(i);
                hit_entry = hit_entry | cell_q[i];
            end
        end
    end

    assign any_match = |match;
    assign expired   = ttl_on && (hit_entry.expiry < r_time);

    // ---------------- insert decision ----------------
    assign cap_ext = CW'(r_cap);
    always_comb begin
        if (cap_ext == '0) begin
            cap_eff = CW'(1);
        end else if (cap_ext > MAX_C) begin
            cap_eff = MAX_C;
        end else begin
            cap_eff = cap_ext;
        end
    end

    assign evict   = (CW'(r_occ) >= cap_eff);
    assign lru_idx = PW'(r_occ - OCC_W'(1));
    assign ins_pos = evict ? lru_idx : PW'(r_occ);

    assign ins_entry.valid  = 1'b1;
    assign ins_entry.key    = r_key;
    assign ins_entry.value  = r_value;
    assign ins_entry.expiry = ttl_on ? r_new_exp : '0;

    assign exp_sum = {1'b0, r_time} + {1'b0, r_ttl};

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            lce_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = lce_pkg::ST_EXEC;
                end
            end
            lce_pkg::ST_EXEC: begin
                if (r_cmd == lce_pkg::CMD_PUT && any_match && expired) begin
                    n_state = lce_pkg::ST_INSERT;
                end else begin
                    n_state = lce_pkg::ST_IDLE;
                end
            end
            lce_pkg::ST_INSERT: begin
                n_state = lce_pkg::ST_IDLE;
            end
            default: begin
                n_state = lce_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- actions and result ----------------
    always_comb begin
        cell_ctl.op          = lce_pkg::CELL_HOLD;
        cell_ctl.key         = i_in.key;
        cell_pos             = '0;
        new_entry            = hit_entry;
        n_done               = 1'b0;
        n_occ                = r_occ;
        n_time               = r_time;
        n_result.status      = lce_pkg::STS_MISS;
        n_result.read_value  = '0;
        n_result.evicted_key = '0;
        case (r_state)
            lce_pkg::ST_IDLE: begin
                if (start) begin
                    cell_ctl.op = lce_pkg::CELL_MATCH;
                end
            end
            lce_pkg::ST_EXEC: begin
                case (r_cmd)
                    lce_pkg::CMD_GET: begin
                        n_done = 1'b1;
                        if (any_match && expired) begin
                            cell_ctl.op     = lce_pkg::CELL_PULL;
                            cell_pos        = pos_m;
                            n_occ           = r_occ - OCC_W'(1);
                            n_result.status = lce_pkg::STS_EXPIRED;
                        end else if (any_match) begin
                            cell_ctl.op         = lce_pkg::CELL_PUSH;
                            cell_pos            = pos_m;
                            n_result.status     = lce_pkg::STS_HIT;
                            n_result.read_value = hit_entry.value;
                        end
                    end
                    lce_pkg::CMD_PUT: begin
                        if (any_match && !expired) begin
                            n_done           = 1'b1;
                            cell_ctl.op      = lce_pkg::CELL_PUSH;
                            cell_pos         = pos_m;
                            new_entry.value  = r_value;
                            new_entry.expiry = ttl_on ? r_new_exp : hit_entry.expiry;
                            n_result.status  = lce_pkg::STS_UPDATED;
                        end else if (any_match) begin
                            // stale key: drop it now, insert on the next cycle
                            cell_ctl.op = lce_pkg::CELL_PULL;
                            cell_pos    = pos_m;
                            n_occ       = r_occ - OCC_W'(1);
                        end else begin
                            n_done      = 1'b1;
                            cell_ctl.op = lce_pkg::CELL_PUSH;
                            cell_pos    = ins_pos;
                            new_entry   = ins_entry;
                            if (evict) begin
                                n_result.status      = lce_pkg::STS_EVICTED;
                                n_result.evicted_key = cell_q[lru_idx].key;
                            end else begin
                                n_result.status = lce_pkg::STS_INSERTED;
                                n_occ           = r_occ + OCC_W'(1);
                            end
                        end
                    end
                    lce_pkg::CMD_TICK: begin
                        n_done          = 1'b1;
                        n_result.status = lce_pkg::STS_TICK;
                        if (r_time != '1) begin
                            n_time = r_time + lce_pkg::TIME_W'(1);
                        end
                    end
                    default: begin
                        n_done = 1'b1;
                    end
                endcase
            end
            lce_pkg::ST_INSERT: begin
                n_done      = 1'b1;
                cell_ctl.op = lce_pkg::CELL_PUSH;
                cell_pos    = ins_pos;
                new_entry   = ins_entry;
                if (evict) begin
                    n_result.status      = lce_pkg::STS_EVICTED;
                    n_result.evicted_key = cell_q[lru_idx].key;
                end else begin
                    n_result.status = lce_pkg::STS_INSERTED;
                    n_occ           = r_occ + OCC_W'(1);
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
        n_result.occupancy = lce_pkg::OCC_OUT_W'(n_occ);
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lce_pkg::ST_IDLE;
            r_cap   <= lce_pkg::CAP_RESET;
            r_ttl   <= '0;
            r_time  <= '0;
            r_occ   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_time  <= n_time;
            r_occ   <= n_occ;
            r_done  <= n_done;
            if (i_cfg_we) begin
                case (lce_pkg::t_cfg_idx'(i_cfg_idx))
                    lce_pkg::CFG_CAPACITY: r_cap <= i_cfg_data[lce_pkg::CAP_W-1:0];
                    lce_pkg::CFG_TTL:      r_ttl <= i_cfg_data;
                    default: begin
                        r_cap <= r_cap;
                    end
                endcase
            end
        end
    end

    // input beat and expiry for a stored entry, captured at accept
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= lce_pkg::t_cmd'(i_in.command);
            r_key     <= i_in.key;
            r_value   <= i_in.value;
            r_new_exp <= exp_sum[lce_pkg::TIME_W] ? '1 : exp_sum[lce_pkg::TIME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_done) begin
            r_result <= n_result;
        end
    end

    assign o_done = r_done;
    assign o_out  = r_result;

endmodule

`default_nettype wire

// File: hw/rtl/lce_checker.sv
// lce_checker: port-level checks on lru_cache_with_expiry, attached by bind
// depends on lce_pkg and the top level's port list
`default_nettype none

module lce_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             o_done,
    input wire lce_pkg::t_result o_out
);

    // an accepted beat always occupies the block for the following cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("block not busy after accepting a beat");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("results on consecutive cycles");

    a_evict_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_out.status != lce_pkg::STS_EVICTED) |-> (o_out.evicted_key == '0))
        else $error("evicted key set without an eviction");

    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_out.status != lce_pkg::STS_HIT) |-> (o_out.read_value == '0))
        else $error("read value set without a hit");

endmodule

bind lru_cache_with_expiry lce_checker u_lce_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_out   (o_out)
);

`default_nettype wire

// File: test/tb_top.sv
// tb_top: self-checking bench for lru_cache_with_expiry, directed table then random phases
// a predictor of the store computes each result; depends on lce_pkg and the rtl only
`timescale 1ns / 1ps

module tb_top;
    import lce_pkg::*;

    localparam int          DEPTH        = 16;
    localparam int          POOL_SIZE    = 24;
    localparam logic [1:0]  CMD_RESERVED = 2'd3;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        start      = 1'b0;
    logic        busy;
    t_cmd_in     i_in       = '0;
    logic        o_done;
    t_result     o_out;
    logic        i_cfg_we   = 1'b0;
    t_cfg_idx    i_cfg_idx  = CFG_CAPACITY;
    logic [31:0] i_cfg_data = '0;

    lru_cache_with_expiry dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .o_done     (o_done),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow copy of the store
    logic        cache_valid [DEPTH];
    logic [31:0] cache_key   [DEPTH];
    logic [31:0] cache_val   [DEPTH];
    logic [31:0] cache_exp   [DEPTH];
    int unsigned cache_rank  [DEPTH];
    logic [31:0] now_ticks   = '0;
    logic [4:0]  cap_reg     = CAP_RESET;
    logic [31:0] ttl_reg     = '0;

    t_result     expected_results [$];
    t_result     head;
    int          error_count = 0;
    int          burst_left  = 0;

    typedef struct {
        bit          is_cfg;
        t_cfg_idx    reg_idx;
        logic [31:0] reg_data;
        t_cmd_in     beat;
        bit          fixed;
        t_result     want;
    } t_row;

    t_row        rows [$];

    function automatic void add_row(t_row row);
        rows.insert(rows.size(), row);
    endfunction

    function automatic int find_slot(logic [31:0] k);
        for (int i = 0; i < DEPTH; i++)
            if (cache_valid[i] && cache_key[i] == k) return i;
        return -1;
    endfunction

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < DEPTH; i++)
            if (cache_valid[i]) n++;
        return n;
    endfunction

    function automatic bit is_stale(int i);
        return ttl_reg != 0 && cache_exp[i] < now_ticks;
    endfunction

    function automatic logic [31:0] expiry_now();
        logic [32:0] s;
        s = {1'b0, now_ticks} + {1'b0, ttl_reg};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void promote(int i);
        int unsigned r;
        r = cache_rank[i];
        for (int j = 0; j < DEPTH; j++)
            if (cache_valid[j] && cache_rank[j] < r) cache_rank[j]++;
        cache_rank[i] = 0;
    endfunction

    function automatic void drop(int i);
        int unsigned r;
        r = cache_rank[i];
        cache_valid[i] = 1'b0;
        cache_rank[i]  = 0;
        for (int j = 0; j < DEPTH; j++)
            if (cache_valid[j] && cache_rank[j] > r) cache_rank[j]--;
    endfunction

    function automatic t_result cache_step(t_cmd_in b);
        t_result r;
        int      hit;
        int      cap;
        int      lru;
        int      slot;
        r = '0;
        r.status = STS_MISS;
        hit = find_slot(b.key);
        case (b.command)
            CMD_GET: begin
                if (hit >= 0) begin
                    if (is_stale(hit)) begin
                        drop(hit);
                        r.status = STS_EXPIRED;
                    end else begin
                        promote(hit);
                        r.read_value = cache_val[hit];
                        r.status = STS_HIT;
                    end
                end
            end
            CMD_PUT: begin
                // a stale key is dropped quietly and the put becomes an insert
                if (hit >= 0 && is_stale(hit)) begin
                    drop(hit);
                    hit = -1;
                end
                if (hit >= 0) begin
                    cache_val[hit] = b.value;
                    promote(hit);
                    if (ttl_reg != 0) cache_exp[hit] = expiry_now();
                    r.status = STS_UPDATED;
                end else begin
                    cap = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : int'(cap_reg));
                    r.status = STS_INSERTED;
                    if (live_count() >= cap) begin
                        lru = -1;
                        for (int j = 0; j < DEPTH; j++)
                            if (cache_valid[j] && (lru < 0 || cache_rank[j] > cache_rank[lru]))
                                lru = j;
                        if (lru >= 0) begin
                            r.evicted_key = cache_key[lru];
                            drop(lru);
                            r.status = STS_EVICTED;
                        end
                    end
                    slot = 0;
                    while (slot < DEPTH && cache_valid[slot]) slot++;
                    if (slot < DEPTH) begin
                        for (int j = 0; j < DEPTH; j++)
                            if (cache_valid[j]) cache_rank[j]++;
                        cache_valid[slot] = 1'b1;
                        cache_key[slot]   = b.key;
                        cache_val[slot]   = b.value;
                        cache_exp[slot]   = (ttl_reg != 0) ? expiry_now() : 32'h0;
                        cache_rank[slot]  = 0;
                    end
                end
            end
            CMD_TICK: begin
                if (now_ticks != 32'hFFFF_FFFF) now_ticks++;
                r.status = STS_TICK;
            end
            default: ;
        endcase
        r.occupancy = OCC_OUT_W'(live_count());
        return r;
    endfunction

    function automatic t_row beat_row(logic [1:0] cmd, logic [31:0] k, logic [31:0] v);
        t_row row;
        row = '{is_cfg: 1'b0, reg_idx: CFG_CAPACITY, reg_data: '0,
                beat: '0, fixed: 1'b0, want: '0};
        row.beat.command = cmd;
        row.beat.key     = k;
        row.beat.value   = v;
        return row;
    endfunction

    function automatic t_row fixed_row(logic [1:0] cmd, logic [31:0] k, logic [31:0] v,
                                       t_status st, logic [31:0] rv, logic [31:0] ek,
                                       logic [4:0] occ);
        t_row row;
        row = beat_row(cmd, k, v);
        row.fixed            = 1'b1;
        row.want.status      = st;
        row.want.read_value  = rv;
        row.want.evicted_key = ek;
        row.want.occupancy   = occ;
        return row;
    endfunction

    function automatic t_row cfg_row(t_cfg_idx idx, logic [31:0] data);
        t_row row;
        row = '{is_cfg: 1'b0, reg_idx: CFG_CAPACITY, reg_data: '0,
                beat: '0, fixed: 1'b0, want: '0};
        row.is_cfg   = 1'b1;
        row.reg_idx  = idx;
        row.reg_data = data;
        return row;
    endfunction

    task automatic report_error(string what, logic [31:0] got, logic [31:0] want);
        if (error_count < 40)
            $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // start stays high from one beat to the next inside a burst
    task automatic send_beat(t_cmd_in b, bit fixed, t_result want);
        t_result pred;
        start <= 1'b1;
        i_in  <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pred = cache_step(b);
        expected_results.insert(expected_results.size(), fixed ? want : pred);
    endtask

    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(0, 6);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_CAPACITY) cap_reg = data[4:0];
        else ttl_reg = data;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            if (expected_results.size() == 0) begin
                report_error("result with nothing expected, status", 32'(o_out.status), '0);
            end else begin
                head = expected_results.pop_front();
                if (o_out.status !== head.status)
                    report_error("status", 32'(o_out.status), 32'(head.status));
                if (o_out.read_value !== head.read_value)
                    report_error("read_value", o_out.read_value, head.read_value);
                if (o_out.evicted_key !== head.evicted_key)
                    report_error("evicted_key", o_out.evicted_key, head.evicted_key);
                if (o_out.occupancy !== head.occupancy)
                    report_error("occupancy", 32'(o_out.occupancy), 32'(head.occupancy));
            end
        end
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        logic [31:0] key_pool [POOL_SIZE];
        t_cmd_in     b;
        int          pick;
        logic [4:0]  cap_sel;
        logic [31:0] ttl_sel;

        for (int i = 0; i < DEPTH; i++) begin
            cache_valid[i] = 1'b0;
            cache_key[i]   = '0;
            cache_val[i]   = '0;
            cache_exp[i]   = '0;
            cache_rank[i]  = 0;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store, extremes, eviction order, capacity edge values, expiry
        add_row(fixed_row(CMD_GET, 32'h0, 32'h0, STS_MISS, 0, 0, 0));
        add_row(fixed_row(CMD_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, STS_MISS, 0, 0, 0));
        add_row(fixed_row(CMD_PUT, 32'h0, 32'hFFFF_FFFF, STS_INSERTED, 0, 0, 1));
        add_row(fixed_row(CMD_PUT, 32'hFFFF_FFFF, 32'h0, STS_INSERTED, 0, 0, 2));
        add_row(fixed_row(CMD_GET, 32'hFFFF_FFFF, 32'h5, STS_HIT, 32'h0, 0, 2));
        add_row(fixed_row(CMD_PUT, 32'h0, 32'h1234_5678, STS_UPDATED, 0, 0, 2));
        add_row(fixed_row(CMD_GET, 32'h0, 32'h0, STS_HIT, 32'h1234_5678, 0, 2));
        add_row(cfg_row(CFG_CAPACITY, 32'd2));
        add_row(fixed_row(CMD_PUT, 32'h5, 32'h55, STS_EVICTED, 0, 32'hFFFF_FFFF, 2));
        // capacity zero holds one entry; lowering it drops only one per insert
        add_row(cfg_row(CFG_CAPACITY, 32'd0));
        add_row(fixed_row(CMD_PUT, 32'h6, 32'h66, STS_EVICTED, 0, 32'h0, 2));
        add_row(fixed_row(CMD_PUT, 32'h7, 32'h77, STS_EVICTED, 0, 32'h5, 2));
        add_row(fixed_row(CMD_TICK, 32'h0, 32'h0, STS_TICK, 0, 0, 2));
        // entries stored with ttl off carry expiry zero and go stale at once
        add_row(cfg_row(CFG_TTL, 32'd2));
        add_row(fixed_row(CMD_GET, 32'h6, 32'h0, STS_EXPIRED, 0, 0, 1));
        add_row(cfg_row(CFG_CAPACITY, 32'd31));
        add_row(fixed_row(CMD_PUT, 32'h7, 32'hA5A5_A5A5, STS_INSERTED, 0, 0, 1));
        add_row(beat_row(CMD_PUT, 32'h8, 32'h5A5A_5A5A));
        add_row(beat_row(CMD_GET, 32'h7, 32'h0));
        repeat (4) add_row(beat_row(CMD_TICK, 32'hDEAD_BEEF, 32'hCAFE_F00D));
        add_row(beat_row(CMD_GET, 32'h8, 32'h0));
        add_row(beat_row(CMD_PUT, 32'h7, 32'h1));
        // expiry sum saturates
        add_row(cfg_row(CFG_TTL, 32'hFFFF_FFFF));
        add_row(beat_row(CMD_PUT, 32'h9, 32'h9));
        add_row(beat_row(CMD_TICK, 32'h0, 32'h0));
        add_row(beat_row(CMD_GET, 32'h9, 32'h0));
        add_row(beat_row(CMD_GET, 32'h7, 32'h0));

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                write_reg(rows[i].reg_idx, rows[i].reg_data);
            end else begin
                send_beat(rows[i].beat, rows[i].fixed, rows[i].want);
                pace();
            end
        end

        // random phases, each under its own register setting
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       begin cap_sel = 5'd16; ttl_sel = 32'd0;          end
                1:       begin cap_sel = 5'd1;  ttl_sel = 32'd0;          end
                2:       begin cap_sel = 5'd4;  ttl_sel = 32'd3;          end
                3:       begin cap_sel = 5'd31; ttl_sel = 32'd10;         end
                4:       begin cap_sel = 5'd0;  ttl_sel = 32'd1;          end
                5:       begin cap_sel = 5'd8;  ttl_sel = 32'hFFFF_FFFF;  end
                6:       begin cap_sel = 5'($urandom_range(0, 31));
                               ttl_sel = $urandom_range(0, 20);           end
                default: begin cap_sel = 5'd16; ttl_sel = $urandom();     end
            endcase
            // upper bits of the capacity word are don't-care
            write_reg(CFG_CAPACITY, ($urandom() & 32'hFFFF_FFE0) | 32'(cap_sel));
            write_reg(CFG_TTL, ttl_sel);

            for (int i = 0; i < POOL_SIZE; i++) begin
                if (i == 0) key_pool[i] = 32'h0;
                else if (i == 1) key_pool[i] = 32'hFFFF_FFFF;
                else if ($urandom_range(0, 1)) key_pool[i] = $urandom();
                else key_pool[i] = $urandom_range(2, 50);
            end

            for (int n = 0; n < 150; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) b.command = CMD_GET;
                else if (pick < 80) b.command = CMD_PUT;
                else if (pick < 94) b.command = CMD_TICK;
                else b.command = CMD_RESERVED;
                b.key   = ($urandom_range(0, 9) == 0) ? $urandom()
                                                      : key_pool[$urandom_range(0, POOL_SIZE - 1)];
                b.value = $urandom();
                send_beat(b, 1'b0, '0);
                pace();
            end
        end

        drain();
        repeat (6) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
